>>> hw/rtl/skt_pkg.sv
package skt_pkg;

   // Table geometry
   localparam int CAPACITY = 16;
   localparam int IDX_W    = 4;
   localparam int CNT_W    = 5;
   localparam int KEY_W    = 16;
   localparam int PAY_W    = 32;

   // Request kinds carried in req_tuser
   typedef enum logic [2:0] {
      OP_INSERT       = 3'd0,
      OP_REMOVE       = 3'd1,
      OP_QUERY        = 3'd2,
      OP_READ_INDEX   = 3'd3,
      OP_READ_NEXT    = 3'd4,
      OP_CURSOR_RESET = 3'd5
   } req_op_type;

   // Result status carried in rsp_tuser
   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_END      = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   // Sequencer states
   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   // One stored entry
   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
   } entry_type;

   // Per-cycle commands broadcast to every cell
   typedef struct packed {
      logic capture;
      logic ins;
      logic rem;
   } ctrl_type;

endpackage

>>> hw/rtl/skt_cell.sv
module skt_cell (
   input  logic                        clock,
   input  skt_pkg::ctrl_type           ctrl,
   input  logic                        occupied,
   input  logic                        head,
   input  logic [skt_pkg::KEY_W-1:0]   cmp_key,
   input  skt_pkg::entry_type          new_entry,
   input  skt_pkg::entry_type          left_entry,
   input  skt_pkg::entry_type          right_entry,
   input  logic                        left_ltp,
   input  logic                        left_lt,
   output skt_pkg::entry_type          entry,
   output logic                        ltp,
   output logic                        lt,
   output logic                        first
);

   skt_pkg::entry_type entry_ff, entry_in;
   logic               ltp_ff, ltp_in;
   logic               lt_ff, lt_in;
   logic               eq_ff, eq_in;

   // Compare the stored key against the incoming key
   always_comb begin
      lt_in  = occupied && (entry_ff.key < cmp_key);
      eq_in  = occupied && (entry_ff.key == cmp_key);
      // an equal key at the head counts as smaller, so the new item lands behind it
      ltp_in = lt_in || (head && eq_in);
   end

   // Pick hold, new item, or a neighbor's entry
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins) begin
         if (!ltp_ff) begin
            entry_in = left_ltp ? new_entry : left_entry;
         end
      end else if (ctrl.rem) begin
         if (!lt_ff) begin
            entry_in = right_entry;
         end
      end
   end

   // Hold compare flags from accept to commit
   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         ltp_ff <= ltp_in;
         lt_ff  <= lt_in;
         eq_ff  <= eq_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign ltp   = ltp_ff;
   assign lt    = lt_ff;
   assign first = eq_ff && !lt_ff && left_lt;

endmodule

>>> hw/rtl/sorted_key_table_top.sv
// Sorted key table: holds up to 16 entries (16-bit key, 32-bit payload) in
// ascending key order in a row of cells, each comparing its key against the
// request key and shifting to a neighbor on insert or remove. Each request is
// first captured, with all cell compares latched; the commit then shifts the
// row, updates count and cursor, and loads the result register. A new request
// is accepted while the previous result still waits on rsp; the commit stalls
// only while that result is not yet taken. Exactly one result follows each
// request. No clearing pass after reset.
module sorted_key_table_top (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // entry_key[15:0], entry_payload[47:16], position[51:48]
   input  logic [2:0]  req_tuser,   // req_type[2:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // found[0], out_key[16:1], out_payload[48:17],
                                    // entry_count[53:49]
   output logic [2:0]  rsp_tuser    // status[2:0]
);

   localparam int N = skt_pkg::CAPACITY;

   skt_pkg::state_type   state_ff, state_in;
   skt_pkg::req_op_type  op_ff;
   skt_pkg::entry_type   req_entry_ff;
   logic [skt_pkg::IDX_W-1:0] pos_ff;

   logic [skt_pkg::CNT_W-1:0] count_ff, count_in;
   logic [skt_pkg::IDX_W-1:0] cur_ff, cur_in;
   logic                      started_ff, started_in;

   logic                      rsp_valid_ff;
   skt_pkg::status_type       rsp_status_ff, status_in;
   logic                      rsp_found_ff, found_in;
   skt_pkg::entry_type        rsp_entry_ff, out_entry;
   logic [skt_pkg::CNT_W-1:0] rsp_count_ff;

   logic                      accept, commit, do_ins, do_rem, use_first, give_entry;
   logic [skt_pkg::CNT_W-1:0] rd_idx, nxt;
   skt_pkg::ctrl_type         ctrl;
   skt_pkg::entry_type        rd_entry;

   skt_pkg::entry_type cell_entry [N];
   logic [N-1:0]       ltp_vec, lt_vec, first_vec, occ_vec, sel_vec;

   // Sequencer: capture, then commit once the result register is free
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         skt_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) state_in = skt_pkg::S_EXEC;
         end
         skt_pkg::S_EXEC: begin
            if (commit) state_in = skt_pkg::S_IDLE;
         end
         default: state_in = skt_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= skt_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign accept = req_tvalid && req_tready;
   assign commit = (state_ff == skt_pkg::S_EXEC) && (!rsp_valid_ff || rsp_tready);

   // Hold the accepted item
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff                <= skt_pkg::req_op_type'(req_tuser);
         req_entry_ff.key     <= req_tdata[15:0];
         req_entry_ff.payload <= req_tdata[47:16];
         pos_ff               <= req_tdata[51:48];
      end
   end

   assign ctrl.capture = accept;
   assign ctrl.ins     = commit && do_ins;
   assign ctrl.rem     = commit && do_rem;

   // Row of cells
   for (genvar i = 0; i < N; i++) begin : g_cell
      assign occ_vec[i] = (skt_pkg::CNT_W'(i) < count_ff);
      assign sel_vec[i] = use_first ? first_vec[i] : (rd_idx == skt_pkg::CNT_W'(i));

      skt_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (occ_vec[i]),
         .head        (i == 0),
         .cmp_key     (req_tdata[15:0]),
         .new_entry   (req_entry_ff),
         .left_entry  ((i == 0) ? req_entry_ff : cell_entry[(i == 0) ? 0 : i-1]),
         .right_entry ((i == N-1) ? cell_entry[i] : cell_entry[(i == N-1) ? i : i+1]),
         .left_ltp    ((i == 0) ? 1'b1 : ltp_vec[(i == 0) ? 0 : i-1]),
         .left_lt     ((i == 0) ? 1'b1 : lt_vec[(i == 0) ? 0 : i-1]),
         .entry       (cell_entry[i]),
         .ltp         (ltp_vec[i]),
         .lt          (lt_vec[i]),
         .first       (first_vec[i])
      );
   end

   // Gather the selected cell's entry
   always_comb begin
      rd_entry = '0;
      for (int i = 0; i < N; i++) begin
         if (sel_vec[i]) rd_entry = rd_entry | cell_entry[i];
      end
   end

   // Decide status, count and cursor for the held item
   always_comb begin
      status_in  = skt_pkg::ST_OK;
      found_in   = 1'b0;
      give_entry = 1'b0;
      count_in   = count_ff;
      cur_in     = cur_ff;
      started_in = started_ff;
      do_ins     = 1'b0;
      do_rem     = 1'b0;
      use_first  = 1'b0;
      nxt        = started_ff ? ({1'b0, cur_ff} + 1'b1) : '0;
      rd_idx     = {1'b0, pos_ff};
      unique case (op_ff)
         skt_pkg::OP_INSERT: begin
            if (count_ff == skt_pkg::CNT_W'(N)) begin
               status_in = skt_pkg::ST_FULL;
            end else begin
               do_ins   = 1'b1;
               count_in = count_ff + 1'b1;
               if (started_ff && !ltp_vec[cur_ff]) cur_in = cur_ff + 1'b1;
            end
         end
         skt_pkg::OP_REMOVE: begin
            use_first = 1'b1;
            if (count_ff == '0) begin
               status_in = skt_pkg::ST_EMPTY;
            end else if (!(|first_vec)) begin
               status_in = skt_pkg::ST_NOTFOUND;
            end else begin
               do_rem     = 1'b1;
               give_entry = 1'b1;
               count_in   = count_ff - 1'b1;
               if (started_ff && !lt_vec[cur_ff]) begin
                  if (cur_ff == '0) started_in = 1'b0;
                  else              cur_in     = cur_ff - 1'b1;
               end
            end
         end
         skt_pkg::OP_QUERY: begin
            use_first = 1'b1;
            if (count_ff == '0) status_in = skt_pkg::ST_EMPTY;
            else                found_in  = |first_vec;
         end
         skt_pkg::OP_READ_INDEX: begin
            if (count_ff == '0) begin
               status_in = skt_pkg::ST_EMPTY;
            end else if ({1'b0, pos_ff} >= count_ff) begin
               status_in = skt_pkg::ST_END;
            end else begin
               give_entry = 1'b1;
               cur_in     = pos_ff;
               started_in = 1'b1;
            end
         end
         skt_pkg::OP_READ_NEXT: begin
            rd_idx = nxt;
            if (count_ff == '0) begin
               status_in = skt_pkg::ST_EMPTY;
            end else if (nxt >= count_ff) begin
               status_in  = skt_pkg::ST_END;
               cur_in     = '0;
               started_in = 1'b0;
            end else begin
               give_entry = 1'b1;
               cur_in     = nxt[skt_pkg::IDX_W-1:0];
               started_in = 1'b1;
            end
         end
         skt_pkg::OP_CURSOR_RESET: begin
            cur_in     = '0;
            started_in = 1'b0;
         end
         default: begin
         end
      endcase
      out_entry = give_entry ? rd_entry : '0;
   end

   // Advance table bookkeeping on commit
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         cur_ff     <= '0;
         started_ff <= 1'b0;
      end else if (commit) begin
         count_ff   <= count_in;
         cur_ff     <= cur_in;
         started_ff <= started_in;
      end
   end

   // Result register: load on commit, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_status_ff <= status_in;
         rsp_found_ff  <= found_in;
         rsp_entry_ff  <= out_entry;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {2'b00, rsp_count_ff, rsp_entry_ff.payload,
                        rsp_entry_ff.key, rsp_found_ff};

   // Cursor stays inside the stored entries while it is on one
   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      started_ff |-> ({1'b0, cur_ff} < count_ff))
      else $error("cursor beyond stored entries");

   // No item is taken in the cycle after one is accepted
   a_two_cycle: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("request accepted during commit");

   // A full answer always reports a full table
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == skt_pkg::ST_FULL)
      |-> (rsp_count_ff == skt_pkg::CNT_W'(N)))
      else $error("full status with spare room");

   // Count changes only on a commit
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !commit |=> $stable(count_ff))
      else $error("count changed without a commit");

endmodule
